@@ sv/rks_pkg.sv @@
// ----------------------------------------------------------------------------
// rks_pkg
// Shared constants and types for the record key sorter.
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int DEPTH  = 16;
  localparam int KEY_W  = 32;
  localparam int TAG_W  = 16;
  localparam int DATA_W = KEY_W + TAG_W;

  // One stored record.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             ins;
    logic             shf;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } ctl_t;

endpackage

@@ sv/record_key_sorter.sv @@
// ----------------------------------------------------------------------------
// record_key_sorter
// Stable insertion sort of a run of keyed records in a chain of cells.
// ----------------------------------------------------------------------------
// Records enter one word per cycle and are placed in ascending key order in a
// chain of DEPTH cells; equal keys keep arrival order. A word with tlast ends
// the run: input then stalls while the chain shifts toward its head and the
// sorted records leave one word per cycle while the receiver is ready, the
// final one with tlast. Records beyond DEPTH are dropped and tuser (overflow)
// is set on every output word of that run. The output register lets the
// next run start loading while the final word still waits.
module record_key_sorter
  import rks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // key_in[31:0], tag_in[47:32]
  input  logic              s_tlast,   // last_in
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // key_out[31:0], tag_out[47:32]
  output logic              m_tlast,   // last_out
  output logic              m_tuser    // overflow
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic dropped;
  logic dropped_next;

  ctl_t ctl;
  rec_t cells [DEPTH];
  logic g     [DEPTH];
  logic [DEPTH-1:0] vld;

  logic             out_valid;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             out_last;
  logic             out_ovf;

  logic in_acc;
  logic full;
  logic out_load;

  localparam rec_t HEAD_REC = '{valid: 1'b1, key: '0, tag: '0};
  localparam rec_t NONE_REC = '{valid: 1'b0, key: '0, tag: '0};

  assign s_tready = (state == ST_LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign full     = vld[DEPTH-1];
  assign out_load = (state == ST_DRAIN) && vld[0] && (!out_valid || m_tready);

  assign ctl.ins = in_acc && !full;
  assign ctl.shf = out_load;
  assign ctl.key = s_tdata[KEY_W-1:0];
  assign ctl.tag = s_tdata[DATA_W-1:KEY_W];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      rec_t prev_rec;
      logic prev_gt;
      rec_t next_rec;

      if (i == 0) begin : g_head
        assign prev_rec = HEAD_REC;
        assign prev_gt  = 1'b0;
      end else begin : g_body
        assign prev_rec = cells[i-1];
        assign prev_gt  = g[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
        assign next_rec = NONE_REC;
      end else begin : g_link
        assign next_rec = cells[i+1];
      end

      rks_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .prev   (prev_rec),
        .prev_g (prev_gt),
        .next   (next_rec),
        .cur    (cells[i]),
        .g      (g[i])
      );

      assign vld[i] = cells[i].valid;
    end
  endgenerate

  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    case (state)
      ST_LOAD: begin
        if (in_acc && full) begin
          dropped_next = 1'b1;
        end
        if (in_acc && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!vld[0] || (out_load && !vld[1])) begin
          state_next   = ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next   = ST_LOAD;
        dropped_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key  <= cells[0].key;
      out_tag  <= cells[0].tag;
      out_last <= !vld[1];
      out_ovf  <= dropped;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_tag, out_key};
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

  // adjacent stored keys never descend
  logic [DEPTH-2:0] order_ok;
  generate
    for (i = 0; i < DEPTH-1; i++) begin : g_ord
      assign order_ok[i] = !vld[i+1] || (cells[i].key <= cells[i+1].key);
    end
  endgenerate

  a_fill_contig : assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, vld} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("cell valid bits not contiguous from head");

  a_sorted : assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("chain out of key order");

  a_last_drain : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> state == ST_DRAIN)
    else $error("end of run did not start output");

endmodule

@@ sv/rks_cell.sv @@
// ----------------------------------------------------------------------------
// rks_cell
// One slot of the insertion chain: holds a record, takes the new record,
// its left neighbor's record on insert, or its right neighbor's on drain.
// ----------------------------------------------------------------------------
module rks_cell
  import rks_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  ctl_t ctl,
  input  rec_t prev,
  input  logic prev_g,
  input  rec_t next,
  output rec_t cur,
  output logic g
);

  rec_t entry;
  rec_t entry_next;

  assign cur = entry;

  always_comb begin
    // strict compare keeps equal keys in arrival order
    g = entry.valid && (entry.key > ctl.key);
    entry_next = entry;
    if (ctl.shf) begin
      entry_next = next;
    end else if (ctl.ins) begin
      if (prev_g) begin
        entry_next = prev;
      end else if (g || (!entry.valid && prev.valid)) begin
        entry_next.valid = 1'b1;
        entry_next.key   = ctl.key;
        entry_next.tag   = ctl.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

@@ verif/rks_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rks_checker
// Watches both streams of the record key sorter and checks its sorted output.
// ----------------------------------------------------------------------------
// Every accepted input word, up to DEPTH per run, goes into a shadow store
// kept in ascending key order, equal keys behind those already there. A word
// with tlast turns the store into a queue of due words, then empties it. Each
// accepted output word is compared field by field with the oldest due word.
module rks_checker
  import rks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // key_in[31:0], tag_in[47:32]
  input  logic              s_tlast,   // last_in
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [DATA_W-1:0] m_tdata,   // key_out[31:0], tag_out[47:32]
  input  logic              m_tlast,   // last_out
  input  logic              m_tuser,   // overflow
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             ovf;
  } sorted_word_t;

  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [TAG_W-1:0] shadow_tags [DEPTH];
  int               shadow_count;
  logic             run_dropped;
  sorted_word_t     sorted_due [$];
  int               out_index;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: word %0d %s got %0h want %0h", $time,
             out_index, what, got, want);
    fail_count = fail_count + 1;
  endtask

  task automatic place_record(input logic [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag);
    int pos;
    if (shadow_count >= DEPTH) begin
      run_dropped = 1'b1;
      return;
    end
    pos = shadow_count;
    while (pos > 0 && shadow_keys[pos-1] > key) begin
      shadow_keys[pos] = shadow_keys[pos-1];
      shadow_tags[pos] = shadow_tags[pos-1];
      pos--;
    end
    shadow_keys[pos] = key;
    shadow_tags[pos] = tag;
    shadow_count++;
  endtask

  task automatic release_run();
    sorted_word_t w;
    for (int k = 0; k < shadow_count; k++) begin
      w.key  = shadow_keys[k];
      w.tag  = shadow_tags[k];
      w.last = (k + 1 == shadow_count);
      w.ovf  = run_dropped;
      sorted_due.push_back(w);
    end
    shadow_count = 0;
    run_dropped  = 1'b0;
  endtask

  always @(posedge clk) begin
    sorted_word_t w;
    if (rst) begin
      shadow_count = 0;
      run_dropped  = 1'b0;
      sorted_due.delete();
      out_index    = 0;
      fail_count   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        place_record(s_tdata[KEY_W-1:0], s_tdata[KEY_W +: TAG_W]);
        if (s_tlast)
          release_run();
      end
      if (m_tvalid && m_tready) begin
        if (sorted_due.size() == 0) begin
          report_mismatch("unexpected, key", 64'(m_tdata[KEY_W-1:0]), 64'd0);
        end else begin
          w = sorted_due.pop_front();
          if (m_tdata[KEY_W-1:0] !== w.key)
            report_mismatch("key", 64'(m_tdata[KEY_W-1:0]), 64'(w.key));
          if (m_tdata[KEY_W +: TAG_W] !== w.tag)
            report_mismatch("tag", 64'(m_tdata[KEY_W +: TAG_W]), 64'(w.tag));
          if (m_tlast !== w.last)
            report_mismatch("tlast", 64'(m_tlast), 64'(w.last));
          if (m_tuser !== w.ovf)
            report_mismatch("overflow", 64'(m_tuser), 64'(w.ovf));
        end
        out_index++;
      end
    end
    pending = sorted_due.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the record key sorter.
// ----------------------------------------------------------------------------
// Sends a few directed runs (extreme keys and tags, equal keys, a single
// record, a full store with the tlast word dropped), then random runs of
// mixed length and key spread, some past capacity, in phases with and without
// sender idling and receiver stalling. Checking lives in rks_checker.
module tb_top;
  import rks_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;
  int                fail_count;
  int                pending;
  int                idle_pct  = 0;
  int                stall_pct = 0;
  int                quiet_cycles = 0;

  always #4 clk = ~clk;

  record_key_sorter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  rks_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("record_key_sorter test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tag, key};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int spread);
    case (spread)
      0: return KEY_W'($urandom);
      1: return KEY_W'($urandom_range(7));
      default: begin
        case ($urandom_range(4))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(KEY_W-1){1'b0}}};
          3: return {1'b0, {(KEY_W-1){1'b1}}};
          default: return KEY_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_run(input int len, input int spread);
    for (int i = 0; i < len; i++)
      send_word(pick_key(spread), TAG_W'($urandom), i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes and equal keys in one run
    send_word('1, '1, 1'b0);
    send_word('0, '0, 1'b0);
    send_word(32'd7, 16'h0001, 1'b0);
    send_word(32'd7, 16'h0002, 1'b0);
    send_word(32'd7, 16'h0003, 1'b1);
    // run of one record
    send_word(32'h8000_0000, 16'h8000, 1'b1);
    // store full, the tlast word is dropped but still ends the run
    for (int i = 0; i < DEPTH; i++)
      send_word(KEY_W'(DEPTH - i), TAG_W'(16'h5a00 + i), 1'b0);
    send_word(32'd1, 16'hdead, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      sent = 0;
      while (sent < 32) begin
        r = $urandom_range(99);
        if (r < 80)
          len = $urandom_range(DEPTH, 1);
        else if (r < 92)
          len = $urandom_range(DEPTH + 4, DEPTH + 1);
        else
          len = DEPTH;
        send_run(len, $urandom_range(2));
        sent += len;
      end
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (pending != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0)
      $display("record_key_sorter test passed");
    else
      $display("record_key_sorter test failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/rks_pkg.sv
sv/rks_cell.sv
sv/record_key_sorter.sv
verif/rks_checker.sv
verif/tb_top.sv
